>>> sv/asfs_pkg.sv
package asfs_pkg;

  // Index and coordinate widths of the block.
  localparam int unsigned INDEX_BITS = 24;
  localparam int unsigned COORD_BITS = 14;

  // Fixed field widths of the channels.
  localparam int unsigned POS_W     = 14;
  localparam int unsigned TEX_W     = 16;
  localparam int unsigned IDX_OUT_W = 24;
  localparam int unsigned THR_W     = 60;

  // Datapath widths: edge differences, multiplier operands, squared norm.
  localparam int unsigned DIFF_W = POS_W + 1;
  localparam int unsigned MUL_W  = 2 * DIFF_W + 1;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned SQ_W   = THR_W;

  // Sequencer step numbers of the norm computation.
  localparam int unsigned STEP_W      = 4;
  localparam int unsigned STEP_DIFF   = 0;
  localparam int unsigned STEP_ISSUE0 = 1;
  localparam int unsigned STEP_ISSUE8 = 9;
  localparam int unsigned STEP_CONS0  = 2;
  localparam int unsigned STEP_CONS8  = 10;
  localparam int unsigned STEP_DECIDE = 11;

  // Result sequence lengths.
  localparam int unsigned RES_W          = 4;
  localparam int unsigned RES_SPLIT      = 10;
  localparam int unsigned RES_WHOLE      = 4;
  localparam int unsigned VERTS_SPLIT    = 6;
  localparam int unsigned VERTS_WHOLE    = 3;
  localparam int unsigned CORNER_LAST    = 2;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FACE   = 1'b1;

  // Products formed by the shared multiplier, in issue order.
  typedef enum logic [3:0] {
    MUL_AY_BZ,
    MUL_AZ_BY,
    MUL_AZ_BX,
    MUL_AX_BZ,
    MUL_AX_BY,
    MUL_AY_BX,
    MUL_CX_CX,
    MUL_CY_CY,
    MUL_CZ_CZ
  } mul_op_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [TEX_W-1:0]        u;
    logic [TEX_W-1:0]        v;
  } corner_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             accept;
    logic [1:0]       slot;
    logic             clear_mesh;
    logic             diff;
    logic             issue;
    mul_op_e          issue_op;
    logic             consume;
    mul_op_e          consume_op;
    logic             decide;
    logic             emit;
    logic [RES_W-1:0] res_idx;
    logic             last;
  } asfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic split;
    logic out_free;
  } asfs_status_t;

  typedef struct packed {
    logic [2:0] a;
    logic [2:0] b;
    logic [2:0] c;
  } face_ofs_t;

  // Vertex offsets of each face relative to the face's base index.
  function automatic face_ofs_t face_ofs(input logic split, input logic [1:0] face);
    face_ofs_t r;
    r = '{a: 3'd0, b: 3'd1, c: 3'd2};
    if (split) begin
      case (face)
        2'd0:    r = '{a: 3'd0, b: 3'd3, c: 3'd5};
        2'd1:    r = '{a: 3'd3, b: 3'd1, c: 3'd4};
        2'd2:    r = '{a: 3'd3, b: 3'd4, c: 3'd5};
        2'd3:    r = '{a: 3'd5, b: 3'd4, c: 3'd2};
        default: r = '{a: 3'd0, b: 3'd1, c: 3'd2};
      endcase
    end
    return r;
  endfunction

  // Keeps the low COORD_BITS of a coordinate and sign-extends from there.
  function automatic logic signed [POS_W-1:0] sext_coord(input logic [POS_W-1:0] raw);
    logic signed [COORD_BITS-1:0] t;
    t = raw[COORD_BITS-1:0];
    return POS_W'(t);
  endfunction

endpackage

>>> sv/asfs_if.sv
interface asfs_in_if import asfs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    start_mesh;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;

  modport source (output valid, start_mesh, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, start_mesh, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface asfs_out_if import asfs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;
  logic signed [POS_W-1:0] out_z;
  logic [TEX_W-1:0]        out_u;
  logic [TEX_W-1:0]        out_v;
  logic [IDX_OUT_W-1:0]    corner_a;
  logic [IDX_OUT_W-1:0]    corner_b;
  logic [IDX_OUT_W-1:0]    corner_c;
  logic                    last;
  logic                    index_overflow;

  modport source (output valid, kind, out_x, out_y, out_z, out_u, out_v, corner_a, corner_b,
                  corner_c, last, index_overflow, input ready);
  modport sink   (input valid, kind, out_x, out_y, out_z, out_u, out_v, corner_a, corner_b,
                  corner_c, last, index_overflow, output ready);
endinterface

>>> sv/asfs_ctrl.sv
module asfs_ctrl import asfs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         start_mesh_i,
  output logic         in_ready_o,
  input  asfs_status_t status_i,
  output asfs_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_GATHER,
    ST_CALC,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [1:0]        count_q, count_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [RES_W-1:0]  res_q, res_d;
  logic              accept;
  logic [1:0]        slot;
  logic [RES_W-1:0]  res_last;

  always_comb begin
    in_ready_o = (state_q == ST_GATHER);
    accept     = in_ready_o && in_valid_i;
    slot       = start_mesh_i ? 2'd0 : count_q;
    res_last   = status_i.split ? RES_W'(RES_SPLIT - 1) : RES_W'(RES_WHOLE - 1);

    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.slot       = slot;
    cmd_o.clear_mesh = accept && start_mesh_i;
    cmd_o.diff       = (state_q == ST_CALC) && (step_q == STEP_W'(STEP_DIFF));
    cmd_o.issue      = (state_q == ST_CALC) && (step_q >= STEP_W'(STEP_ISSUE0))
                       && (step_q <= STEP_W'(STEP_ISSUE8));
    cmd_o.issue_op   = mul_op_e'(STEP_W'(step_q - STEP_W'(STEP_ISSUE0)));
    cmd_o.consume    = (state_q == ST_CALC) && (step_q >= STEP_W'(STEP_CONS0))
                       && (step_q <= STEP_W'(STEP_CONS8));
    cmd_o.consume_op = mul_op_e'(STEP_W'(step_q - STEP_W'(STEP_CONS0)));
    cmd_o.decide     = (state_q == ST_CALC) && (step_q == STEP_W'(STEP_DECIDE));
    cmd_o.emit       = (state_q == ST_EMIT) && status_i.out_free;
    cmd_o.res_idx    = res_q;
    cmd_o.last       = (res_q == res_last);

    state_d = state_q;
    count_d = count_q;
    step_d  = step_q;
    res_d   = res_q;
    case (state_q)
      ST_GATHER: begin
        if (accept) begin
          if (slot == 2'(CORNER_LAST)) begin
            count_d = 2'd0;
            step_d  = '0;
            state_d = ST_CALC;
          end else begin
            count_d = slot + 2'd1;
          end
        end
      end
      ST_CALC: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(STEP_DECIDE)) begin
          res_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd_o.emit) begin
          res_d = res_q + RES_W'(1);
          if (cmd_o.last) begin
            state_d = ST_GATHER;
          end
        end
      end
      default: begin
        state_d = ST_GATHER;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_GATHER;
      count_q <= 2'd0;
      step_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      res_q   <= res_d;
    end
  end

endmodule

>>> sv/asfs_datapath.sv
module asfs_datapath import asfs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [THR_W-1:0]        cfg_wdata_i,
  input  logic [POS_W-1:0]        pos_x_i,
  input  logic [POS_W-1:0]        pos_y_i,
  input  logic [POS_W-1:0]        pos_z_i,
  input  logic [TEX_W-1:0]        tex_u_i,
  input  logic [TEX_W-1:0]        tex_v_i,
  input  asfs_cmd_t               cmd_i,
  output asfs_status_t            status_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic                    kind_o,
  output logic signed [POS_W-1:0] out_x_o,
  output logic signed [POS_W-1:0] out_y_o,
  output logic signed [POS_W-1:0] out_z_o,
  output logic [TEX_W-1:0]        out_u_o,
  output logic [TEX_W-1:0]        out_v_o,
  output logic [IDX_OUT_W-1:0]    corner_a_o,
  output logic [IDX_OUT_W-1:0]    corner_b_o,
  output logic [IDX_OUT_W-1:0]    corner_c_o,
  output logic                    last_o,
  output logic                    index_overflow_o
);

  corner_t                  corner_q [3];
  logic [THR_W-1:0]         thr_q;
  logic signed [DIFF_W-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [MUL_W-1:0]  cx_q, cy_q, cz_q, cx_d, cy_d, cz_d;
  logic [SQ_W-1:0]          sq_q, sq_d;
  logic [INDEX_BITS-1:0]    cnt_q, base_q;
  logic [INDEX_BITS:0]      cnt_next;
  logic                     ovf_q, split_q;

  corner_t                  mid [3];
  corner_t                  vert;
  face_ofs_t                ofs;
  logic [1:0]               face;
  logic                     is_face;
  logic                     out_valid_q;
  logic                     out_free;

  // Midpoint of two signed coordinates, rounded toward minus infinity.
  function automatic logic signed [POS_W-1:0] mid_pos(input logic signed [POS_W-1:0] a,
                                                      input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] s;
    s = (POS_W+1)'(a) + (POS_W+1)'(b);
    return s[POS_W:1];
  endfunction

  function automatic logic [TEX_W-1:0] mid_tex(input logic [TEX_W-1:0] a,
                                               input logic [TEX_W-1:0] b);
    logic [TEX_W:0] s;
    s = (TEX_W+1)'(a) + (TEX_W+1)'(b);
    return s[TEX_W:1];
  endfunction

  function automatic corner_t mid_corner(input corner_t p, input corner_t q);
    corner_t r;
    r.x = mid_pos(p.x, q.x);
    r.y = mid_pos(p.y, q.y);
    r.z = mid_pos(p.z, q.z);
    r.u = mid_tex(p.u, q.u);
    r.v = mid_tex(p.v, q.v);
    return r;
  endfunction

  // Corner store and threshold register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      corner_q[cmd_i.slot] <= '{x: sext_coord(pos_x_i), y: sext_coord(pos_y_i),
                                z: sext_coord(pos_z_i), u: tex_u_i, v: tex_v_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Edge vectors around the second corner.
  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      ax_q <= DIFF_W'(corner_q[0].x) - DIFF_W'(corner_q[1].x);
      ay_q <= DIFF_W'(corner_q[0].y) - DIFF_W'(corner_q[1].y);
      az_q <= DIFF_W'(corner_q[0].z) - DIFF_W'(corner_q[1].z);
      bx_q <= DIFF_W'(corner_q[2].x) - DIFF_W'(corner_q[1].x);
      by_q <= DIFF_W'(corner_q[2].y) - DIFF_W'(corner_q[1].y);
      bz_q <= DIFF_W'(corner_q[2].z) - DIFF_W'(corner_q[1].z);
    end
  end

  // Shared multiplier: one product issued per step, registered and then accumulated.
  always_comb begin
    case (cmd_i.issue_op)
      MUL_AY_BZ: begin op_a = MUL_W'(ay_q); op_b = MUL_W'(bz_q); end
      MUL_AZ_BY: begin op_a = MUL_W'(az_q); op_b = MUL_W'(by_q); end
      MUL_AZ_BX: begin op_a = MUL_W'(az_q); op_b = MUL_W'(bx_q); end
      MUL_AX_BZ: begin op_a = MUL_W'(ax_q); op_b = MUL_W'(bz_q); end
      MUL_AX_BY: begin op_a = MUL_W'(ax_q); op_b = MUL_W'(by_q); end
      MUL_AY_BX: begin op_a = MUL_W'(ay_q); op_b = MUL_W'(bx_q); end
      MUL_CX_CX: begin op_a = cx_q; op_b = cx_q; end
      MUL_CY_CY: begin op_a = cy_q; op_b = cy_q; end
      MUL_CZ_CZ: begin op_a = cz_q; op_b = cz_q; end
      default:   begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    cz_d = cz_q;
    sq_d = sq_q;
    case (cmd_i.consume_op)
      MUL_AY_BZ: cx_d = MUL_W'(prod_q);
      MUL_AZ_BY: cx_d = cx_q - MUL_W'(prod_q);
      MUL_AZ_BX: cy_d = MUL_W'(prod_q);
      MUL_AX_BZ: cy_d = cy_q - MUL_W'(prod_q);
      MUL_AX_BY: cz_d = MUL_W'(prod_q);
      MUL_AY_BX: cz_d = cz_q - MUL_W'(prod_q);
      MUL_CX_CX: sq_d = SQ_W'(prod_q);
      MUL_CY_CY: sq_d = sq_q + SQ_W'(prod_q);
      MUL_CZ_CZ: sq_d = sq_q + SQ_W'(prod_q);
      default:   sq_d = sq_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      prod_q <= op_a * op_b;
    end
    if (cmd_i.consume) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d;
      sq_q <= sq_d;
    end
  end

  // Split decision and vertex counter.
  always_comb begin
    cnt_next = (INDEX_BITS+1)'(cnt_q)
             + ((sq_q >= thr_q) ? (INDEX_BITS+1)'(VERTS_SPLIT) : (INDEX_BITS+1)'(VERTS_WHOLE));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      split_q <= 1'b0;
    end else if (cmd_i.clear_mesh) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.decide) begin
      cnt_q   <= cnt_next[INDEX_BITS-1:0];
      ovf_q   <= ovf_q | cnt_next[INDEX_BITS];
      split_q <= (sq_q >= thr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      base_q <= cnt_q;
    end
  end

  // Result formation.
  always_comb begin
    mid[0] = mid_corner(corner_q[0], corner_q[1]);
    mid[1] = mid_corner(corner_q[1], corner_q[2]);
    mid[2] = mid_corner(corner_q[2], corner_q[0]);

    case (cmd_i.res_idx[2:0])
      3'd0:    vert = corner_q[0];
      3'd1:    vert = corner_q[1];
      3'd2:    vert = corner_q[2];
      3'd3:    vert = mid[0];
      3'd4:    vert = mid[1];
      3'd5:    vert = mid[2];
      default: vert = '0;
    endcase

    if (split_q) begin
      is_face = (cmd_i.res_idx >= RES_W'(VERTS_SPLIT));
      face    = 2'(cmd_i.res_idx - RES_W'(VERTS_SPLIT));
    end else begin
      is_face = (cmd_i.res_idx >= RES_W'(VERTS_WHOLE));
      face    = 2'd0;
    end
    ofs = face_ofs(split_q, face);
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      last_o           <= cmd_i.last;
      index_overflow_o <= ovf_q;
      if (is_face) begin
        kind_o     <= KIND_FACE;
        out_x_o    <= '0;
        out_y_o    <= '0;
        out_z_o    <= '0;
        out_u_o    <= '0;
        out_v_o    <= '0;
        corner_a_o <= IDX_OUT_W'(INDEX_BITS'(base_q + INDEX_BITS'(ofs.a)));
        corner_b_o <= IDX_OUT_W'(INDEX_BITS'(base_q + INDEX_BITS'(ofs.b)));
        corner_c_o <= IDX_OUT_W'(INDEX_BITS'(base_q + INDEX_BITS'(ofs.c)));
      end else begin
        kind_o     <= KIND_VERTEX;
        out_x_o    <= vert.x;
        out_y_o    <= vert.y;
        out_z_o    <= vert.z;
        out_u_o    <= vert.u;
        out_v_o    <= vert.v;
        corner_a_o <= '0;
        corner_b_o <= '0;
        corner_c_o <= '0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.split    = split_q;
  assign status_o.out_free = out_free;

endmodule

>>> sv/area_selective_face_subdivision.sv
// The first and second corner of a face are each taken in the gather state and give no result.
// The third corner starts the norm computation, run on one shared multiplier (nine products),
// before its first result registers; then one result per cycle, 4 or 10 of them, at full ready.
// New corners are taken only after the last result of the current face has gone to the output register.
// Reset (async, active low) clears the threshold, corner count, vertex counter and overflow flag.
module area_selective_face_subdivision import asfs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_wdata_i,
  asfs_in_if.sink          in_ch,
  asfs_out_if.source       out_ch
);

  // The controller sequences corner gathering, the cross-product norm steps
  // and the result stream; the datapath holds the corners, the multiplier,
  // the vertex counter and the output register. The output register lets a
  // new corner transfer while the last result of a face is still waiting.

  asfs_cmd_t    cmd;
  asfs_status_t status;

  asfs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .start_mesh_i (in_ch.start_mesh),
    .in_ready_o   (in_ch.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // Face records carry indices from the running vertex counter; the overflow
  // flag on each result already includes any wrap caused by its own face.
  asfs_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pos_x_i          (in_ch.pos_x),
    .pos_y_i          (in_ch.pos_y),
    .pos_z_i          (in_ch.pos_z),
    .tex_u_i          (in_ch.tex_u),
    .tex_v_i          (in_ch.tex_v),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (out_ch.ready),
    .out_valid_o      (out_ch.valid),
    .kind_o           (out_ch.kind),
    .out_x_o          (out_ch.out_x),
    .out_y_o          (out_ch.out_y),
    .out_z_o          (out_ch.out_z),
    .out_u_o          (out_ch.out_u),
    .out_v_o          (out_ch.out_v),
    .corner_a_o       (out_ch.corner_a),
    .corner_b_o       (out_ch.corner_b),
    .corner_c_o       (out_ch.corner_c),
    .last_o           (out_ch.last),
    .index_overflow_o (out_ch.index_overflow)
  );

endmodule
